### rtl/assert_macros.svh
// Assertion macros shared by the script lexer RTL.
// Each macro expects a signal named clk in the enclosing module; SL_ASSERT_IMP also needs rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, ignored while in reset.
`define SL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent, also across reset.
`define SL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/sl_pkg.sv
// Shared types, codes and keyword tables of the script lexer.
// No dependencies; sl_front, sl_back and script_lexer import it.
`default_nettype none
package sl_pkg;

  localparam int SL_POS_BITS  = 16;
  localparam int SL_QDEPTH    = 4;
  localparam int SL_QPTR_BITS = $clog2(SL_QDEPTH);
  localparam int SL_NKW       = 6;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_COMMENT, MODE_STRING, MODE_INT, MODE_IDENT, MODE_KEYWORD, MODE_OPWAIT
  } mode_t;

  localparam logic [4:0] KIND_STRING = 5'd0;
  localparam logic [4:0] KIND_INT    = 5'd1;
  localparam logic [4:0] KIND_LPAREN = 5'd2;
  localparam logic [4:0] KIND_RPAREN = 5'd3;
  localparam logic [4:0] KIND_LBRACE = 5'd4;
  localparam logic [4:0] KIND_RBRACE = 5'd5;
  localparam logic [4:0] KIND_IDENT  = 5'd10;
  localparam logic [4:0] KIND_EQ     = 5'd13;
  localparam logic [4:0] KIND_ASSIGN = 5'd14;
  localparam logic [4:0] KIND_GT     = 5'd15;
  localparam logic [4:0] KIND_LT     = 5'd16;
  localparam logic [4:0] KIND_NE     = 5'd17;
  localparam logic [4:0] KIND_ADD    = 5'd18;
  localparam logic [4:0] KIND_SUB    = 5'd19;
  localparam logic [4:0] KIND_MUL    = 5'd20;
  localparam logic [4:0] KIND_DIV    = 5'd21;
  localparam logic [4:0] KIND_COMMA  = 5'd22;
  localparam logic [4:0] KIND_GEQ    = 5'd23;
  localparam logic [4:0] KIND_LEQ    = 5'd24;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN = 2'd1;
  localparam logic [1:0] ERR_UNTERM  = 2'd2;

  localparam logic [7:0] SL_KW_TEXT [SL_NKW][5] = '{
    '{"p", "r", "i", "n", "t"},
    '{"g", "e", "t", 8'h00, 8'h00},
    '{"v", "a", "r", 8'h00, 8'h00},
    '{"l", "o", "o", "p", 8'h00},
    '{"e", "l", "s", "e", 8'h00},
    '{"b", "r", "e", "a", "k"}
  };
  localparam logic [2:0] SL_KW_LEN [SL_NKW] = '{3'd5, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5};
  localparam logic [4:0] SL_KW_KIND [SL_NKW] = '{5'd6, 5'd7, 5'd8, 5'd9, 5'd11, 5'd12};

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start_pos;
    logic [15:0] end_pos;
    logic [15:0] line;
    logic [1:0]  err;
  } token_t;

  // Up to two tokens come out of one source byte.
  typedef struct packed {
    token_t first;
    token_t second;
    logic   two;
  } tok_pair_t;

  typedef struct packed {
    logic [SL_QPTR_BITS:0] count;
    logic                  full;
  } q_status_t;

endpackage
`default_nettype wire

### rtl/sl_if.sv
// Channel interfaces of the script lexer: source bytes in, tokens out.
// Depends on nothing.
`default_nettype none
interface sl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_source;
  modport source (output valid, ch, end_of_source, input ready);
  modport sink (input valid, ch, end_of_source, output ready);
endinterface

interface sl_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] start_pos;
  logic [15:0] end_pos;
  logic [15:0] line_number;
  logic [1:0]  error_code;
  logic        last_of_run;
  modport source (output valid, token_kind, start_pos, end_pos, line_number, error_code,
                  last_of_run, input ready);
  modport sink (input valid, token_kind, start_pos, end_pos, line_number, error_code,
                last_of_run, output ready);
endinterface
`default_nettype wire

### rtl/sl_front.sv
// Front end: accepts one source byte per cycle while the token queue is not full, runs the scan state and
// forms up to two tokens per byte. Depends on sl_pkg and sl_if.
`default_nettype none
module sl_front import sl_pkg::*; #(
  parameter int POS_BITS = SL_POS_BITS
) (
  input  logic       clk,
  input  logic       rst,
  sl_in_if.sink      inp,
  input  q_status_t  qstat,
  output logic       push,
  output tok_pair_t  pair
);

  mode_t               mode, mode_next;
  logic [POS_BITS-1:0] tok_start, tok_start_next;
  logic [POS_BITS-1:0] pos, pos_next;
  logic [15:0]         line, line_next;
  logic [7:0]          op_char, op_char_next;
  logic [SL_NKW-1:0]   kw_mask, kw_mask_next;
  logic [2:0]          kw_fill, kw_fill_next;
  logic                esc, esc_next;

  logic                accept;
  logic [7:0]          c;
  logic [POS_BITS-1:0] prev;
  logic                is_let, is_dig, is_ws, is_nl;
  logic [SL_NKW-1:0]   kw_hit, kw_full, kw_first;
  logic [4:0]          kw_kind_hit;
  token_t              res [2];
  logic [1:0]          n;
  logic                do_idle;

  function automatic logic [15:0] pos16(input logic [POS_BITS-1:0] x);
    logic [31:0] w;
    w = 32'(x);
    return w[15:0];
  endfunction

  function automatic token_t mk(input logic [4:0] k, input logic [POS_BITS-1:0] s,
                                input logic [POS_BITS-1:0] e, input logic [15:0] l,
                                input logic [1:0] er);
    token_t t;
    t.kind = k;
    t.start_pos = pos16(s);
    t.end_pos = pos16(e);
    t.line = l;
    t.err = er;
    return t;
  endfunction

  function automatic token_t op_single(input logic [7:0] oc, input logic [POS_BITS-1:0] s,
                                       input logic [15:0] l);
    token_t t;
    case (oc)
      "=":     t = mk(KIND_ASSIGN, s, s, l, ERR_NONE);
      "<":     t = mk(KIND_LT, s, s, l, ERR_NONE);
      ">":     t = mk(KIND_GT, s, s, l, ERR_NONE);
      default: t = mk(KIND_STRING, s, s, l, ERR_UNKNOWN);
    endcase
    return t;
  endfunction

  assign accept = inp.valid & inp.ready;
  assign inp.ready = !qstat.full;
  assign c = inp.ch;
  assign prev = pos - 1'b1;

  assign is_let = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  assign is_dig = c >= "0" && c <= "9";
  assign is_nl  = c == 8'h0A;
  assign is_ws  = c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D;

  // Keyword candidates are tracked as a mask; no keyword is a prefix of another.
  always_comb begin
    kw_kind_hit = KIND_IDENT;
    for (int k = 0; k < SL_NKW; k++) begin
      kw_first[k] = SL_KW_TEXT[k][0] == c;
      kw_hit[k]   = kw_mask[k] && (kw_fill < SL_KW_LEN[k]) && (kw_fill < 3'd5) &&
                    (SL_KW_TEXT[k][kw_fill] == c);
      kw_full[k]  = kw_hit[k] && (kw_fill + 3'd1 == SL_KW_LEN[k]);
      if (kw_full[k]) kw_kind_hit = SL_KW_KIND[k];
    end
  end

  always_comb begin
    mode_next      = mode;
    tok_start_next = tok_start;
    pos_next       = pos + 1'b1;
    line_next      = line;
    op_char_next   = op_char;
    kw_mask_next   = kw_mask;
    kw_fill_next   = kw_fill;
    esc_next       = esc;
    res[0]         = mk(KIND_STRING, pos, pos, line, ERR_NONE);
    res[1]         = res[0];
    n              = 2'd0;
    do_idle        = 1'b0;

    case (mode)
      MODE_COMMENT: begin
        if (is_nl) begin
          mode_next = MODE_IDLE;
          if (line != 16'hFFFF) line_next = line + 16'd1;
        end
      end
      MODE_STRING: begin
        if (esc && (c == "\"" || c == "\\")) begin
          esc_next = 1'b0;
        end else if (c == "\\") begin
          esc_next = 1'b1;
        end else begin
          esc_next = 1'b0;
          if (c == "\"" || c == "'") begin
            res[0] = mk(KIND_STRING, tok_start, pos, line, ERR_NONE);
            n = 2'd1;
            mode_next = MODE_IDLE;
          end else if (is_nl) begin
            res[0] = mk(KIND_STRING, tok_start, pos, line, ERR_UNTERM);
            n = 2'd1;
            if (line != 16'hFFFF) line_next = line + 16'd1;
            mode_next = MODE_IDLE;
          end
        end
      end
      MODE_INT: begin
        if (!is_dig) begin
          res[0] = mk(KIND_INT, tok_start, prev, line, ERR_NONE);
          n = 2'd1;
          do_idle = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (!is_let) begin
          res[0] = mk(KIND_IDENT, tok_start, prev, line, ERR_NONE);
          n = 2'd1;
          do_idle = 1'b1;
        end
      end
      MODE_KEYWORD: begin
        if (!is_let) begin
          res[0] = mk(KIND_IDENT, tok_start, prev, line, ERR_NONE);
          n = 2'd1;
          do_idle = 1'b1;
        end else if (|kw_full) begin
          res[0] = mk(kw_kind_hit, tok_start, pos, line, ERR_NONE);
          n = 2'd1;
          mode_next = MODE_IDLE;
          kw_fill_next = 3'd0;
        end else if (|kw_hit) begin
          kw_mask_next = kw_hit;
          kw_fill_next = kw_fill + 3'd1;
        end else begin
          mode_next = MODE_IDENT;
        end
      end
      MODE_OPWAIT: begin
        if (c == "=") begin
          case (op_char)
            "=":     res[0] = mk(KIND_EQ, tok_start, pos, line, ERR_NONE);
            "<":     res[0] = mk(KIND_LEQ, tok_start, pos, line, ERR_NONE);
            ">":     res[0] = mk(KIND_GEQ, tok_start, pos, line, ERR_NONE);
            default: res[0] = mk(KIND_NE, tok_start, pos, line, ERR_NONE);
          endcase
          n = 2'd1;
          mode_next = MODE_IDLE;
        end else begin
          res[0] = op_single(op_char, tok_start, line);
          n = 2'd1;
          do_idle = 1'b1;
        end
      end
      default: do_idle = 1'b1;
    endcase

    if (do_idle) begin
      mode_next = MODE_IDLE;
      if (is_nl) begin
        if (line != 16'hFFFF) line_next = line + 16'd1;
      end else if (c == "#") begin
        mode_next = MODE_COMMENT;
      end else if (is_ws) begin
        mode_next = MODE_IDLE;
      end else if (c == "\"" || c == "'") begin
        mode_next = MODE_STRING;
        tok_start_next = pos;
        esc_next = 1'b0;
      end else if (is_dig) begin
        mode_next = MODE_INT;
        tok_start_next = pos;
      end else if (is_let) begin
        tok_start_next = pos;
        kw_mask_next = kw_first;
        kw_fill_next = 3'd1;
        mode_next = (|kw_first) ? MODE_KEYWORD : MODE_IDENT;
      end else if (c == "=" || c == "<" || c == ">" || c == "!") begin
        tok_start_next = pos;
        op_char_next = c;
        kw_fill_next = 3'd1;
        mode_next = MODE_OPWAIT;
      end else begin
        case (c)
          "(":     res[n[0]] = mk(KIND_LPAREN, pos, pos, line, ERR_NONE);
          ")":     res[n[0]] = mk(KIND_RPAREN, pos, pos, line, ERR_NONE);
          "{":     res[n[0]] = mk(KIND_LBRACE, pos, pos, line, ERR_NONE);
          "}":     res[n[0]] = mk(KIND_RBRACE, pos, pos, line, ERR_NONE);
          "+":     res[n[0]] = mk(KIND_ADD, pos, pos, line, ERR_NONE);
          "-":     res[n[0]] = mk(KIND_SUB, pos, pos, line, ERR_NONE);
          "*":     res[n[0]] = mk(KIND_MUL, pos, pos, line, ERR_NONE);
          "/":     res[n[0]] = mk(KIND_DIV, pos, pos, line, ERR_NONE);
          ",":     res[n[0]] = mk(KIND_COMMA, pos, pos, line, ERR_NONE);
          default: res[n[0]] = mk(KIND_STRING, pos, pos, line, ERR_UNKNOWN);
        endcase
        n = n + 2'd1;
      end
    end

    // At the end of the source any held token is flushed and the scan restarts.
    if (inp.end_of_source) begin
      case (mode_next)
        MODE_INT: begin
          res[n[0]] = mk(KIND_INT, tok_start_next, pos, line, ERR_NONE);
          n = n + 2'd1;
        end
        MODE_IDENT, MODE_KEYWORD: begin
          res[n[0]] = mk(KIND_IDENT, tok_start_next, pos, line, ERR_NONE);
          n = n + 2'd1;
        end
        MODE_OPWAIT: begin
          res[n[0]] = op_single(op_char_next, tok_start_next, line);
          n = n + 2'd1;
        end
        MODE_STRING: begin
          res[n[0]] = mk(KIND_STRING, tok_start_next, pos, line, ERR_UNTERM);
          n = n + 2'd1;
        end
        default: n = n;
      endcase
      mode_next      = MODE_IDLE;
      tok_start_next = '0;
      pos_next       = '0;
      line_next      = 16'd1;
      kw_fill_next   = 3'd0;
      esc_next       = 1'b0;
    end
  end

  assign push        = accept && (n != 2'd0);
  assign pair.first  = res[0];
  assign pair.second = res[1];
  assign pair.two    = n[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      tok_start <= '0;
      pos       <= '0;
      line      <= 16'd1;
      kw_fill   <= 3'd0;
      esc       <= 1'b0;
    end else if (accept) begin
      mode      <= mode_next;
      tok_start <= tok_start_next;
      pos       <= pos_next;
      line      <= line_next;
      kw_fill   <= kw_fill_next;
      esc       <= esc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_char <= op_char_next;
      kw_mask <= kw_mask_next;
    end
  end

endmodule
`default_nettype wire

### rtl/sl_back.sv
// Back end: a short queue of token pairs that hands out one token per
// transaction and marks the last token of each byte. Depends on sl_pkg and sl_if.
`default_nettype none
module sl_back import sl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  tok_pair_t  pair,
  output q_status_t  qstat,
  sl_out_if.source   outp
);

  tok_pair_t               q [SL_QDEPTH];
  logic [SL_QPTR_BITS-1:0] wr, rd;
  logic [SL_QPTR_BITS:0]   count;
  logic                    sel;
  logic                    pop, take;
  tok_pair_t               head;
  token_t                  cur;

  assign head = q[rd];
  assign cur  = sel ? head.second : head.first;
  assign take = outp.valid & outp.ready;
  assign pop  = take & (sel | !head.two);

  assign outp.valid       = count != '0;
  assign outp.token_kind  = cur.kind;
  assign outp.start_pos   = cur.start_pos;
  assign outp.end_pos     = cur.end_pos;
  assign outp.line_number = cur.line;
  assign outp.error_code  = cur.err;
  assign outp.last_of_run = sel | !head.two;

  assign qstat.count = count;
  assign qstat.full  = count == (SL_QPTR_BITS + 1)'(SL_QDEPTH);

  always_ff @(posedge clk) begin
    if (push) q[wr] <= pair;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
      sel   <= 1'b0;
    end else begin
      if (push) wr <= wr + 1'b1;
      if (pop) rd <= rd + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
      if (pop) sel <= 1'b0;
      else if (take) sel <= 1'b1;
    end
  end

endmodule
`default_nettype wire

### rtl/script_lexer.sv
// Script lexer: one source byte per cycle in while the token queue is not full, tokens out.
// A token is written into the token queue when the byte that completes it is accepted.
// Throughput: one byte per cycle while the token queue is not full; a byte that yields two tokens needs two
// output transactions, absorbed by the four-entry token queue.
// Reset: synchronous, active high; scan state returns to idle at line one.
`default_nettype none
`include "assert_macros.svh"
module script_lexer import sl_pkg::*; #(
  parameter int POS_BITS = SL_POS_BITS
) (
  input  logic     clk,
  input  logic     rst,
  sl_in_if.sink    inp,
  sl_out_if.source outp
);

  q_status_t qstat;
  logic      push;
  tok_pair_t pair;

  sl_front #(.POS_BITS(POS_BITS)) u_front (
    .clk   (clk),
    .rst   (rst),
    .inp   (inp),
    .qstat (qstat),
    .push  (push),
    .pair  (pair)
  );

  sl_back u_back (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pair  (pair),
    .qstat (qstat),
    .outp  (outp)
  );

  `SL_ASSERT_IMP(a_err_kind, outp.valid && outp.error_code != ERR_NONE, outp.token_kind == KIND_STRING, "error token with non-zero kind")
  `SL_ASSERT_IMP(a_q_bound, 1'b1, qstat.count <= (SL_QPTR_BITS + 1)'(SL_QDEPTH), "token queue overflow")
  `SL_ASSERT_NEXT(a_rst_empty, rst, !outp.valid, "token offered straight after reset")
  `SL_ASSERT_IMP(a_line_nz, outp.valid, outp.line_number != 16'd0, "line number is zero")

endmodule
`default_nettype wire
